/* hw/rtl/lts_pkg.sv */
// Shared types and constants of the light tracker servo controller.
`default_nettype none

package lts_pkg;

  // Item kinds carried on the input tuser
  typedef enum logic [1:0] {
    OP_TICK     = 2'd0,
    OP_WEB_POS  = 2'd1,
    OP_WEB_MODE = 2'd2
  } op_e;

  // Web mode request codes
  localparam logic [1:0] MODE_AUTO   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;

  // Reply codes
  typedef enum logic [2:0] {
    RPL_NONE   = 3'd0,
    RPL_POS    = 3'd1,
    RPL_AUTO   = 3'd2,
    RPL_MANUAL = 3'd3,
    RPL_REJECT = 3'd4
  } reply_e;

  // Tracking decision
  typedef enum logic [1:0] {
    SIDE_LEFT   = 2'd0,
    SIDE_RIGHT  = 2'd1,
    SIDE_CENTER = 2'd2
  } side_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LIGHT_HYST = 2'd0,
    REG_KNOB_HYST  = 2'd1,
    REG_SENSE_INT  = 2'd2,
    REG_DEBOUNCE   = 2'd3
  } reg_e;

  localparam int CFG_W  = 12;
  localparam int SENS_W = 10;
  localparam int TOG_W  = 12;

  localparam logic [CFG_W-1:0]  LIGHT_HYST_RST = 12'd50;
  localparam logic [CFG_W-1:0]  KNOB_HYST_RST  = 12'd25;
  localparam logic [SENS_W-1:0] SENSE_INT_RST  = 10'd10;
  localparam logic [TOG_W-1:0]  DEBOUNCE_RST   = 12'd200;

  localparam logic [SENS_W-1:0] SENSE_SAT  = 10'd1023;
  localparam logic [TOG_W-1:0]  TOGGLE_SAT = 12'd4095;

  // Position in half degrees
  localparam logic [8:0] POS_MIN   = 9'd2;
  localparam logic [8:0] POS_MAX   = 9'd358;
  localparam logic [8:0] POS_RESET = 9'd180;

  // Angles in whole degrees
  localparam logic [7:0] ANGLE_RESET = 8'd90;
  localparam logic [7:0] ANGLE_MIN   = 8'd1;
  localparam logic [7:0] ANGLE_MAX   = 8'd179;

  // One result beat, packed as it sits in out_tdata (angle lowest)
  typedef struct packed {
    reply_e     reply;
    logic       manual;
    side_e      side;
    logic [7:0] angle;
  } result_t;

  localparam int RES_W = 14;
  localparam int OUT_W = 16;

endpackage

`default_nettype wire

/* hw/rtl/lts_knob_map.sv */
// Knob sample to half-degree mapping: floor(knob * 360 / (2^ADC_BITS - 1)).
`default_nettype none

module lts_knob_map #(
  parameter int ADC_BITS = 12
) (
  input  wire logic [ADC_BITS-1:0] knob,
  output logic      [9:0]          quot
);

  localparam int XW = ADC_BITS + 9;
  localparam int RW = ADC_BITS + 2;
  localparam logic [RW-1:0] FULL = {2'b00, {ADC_BITS{1'b1}}};

  logic [XW-1:0] prod;
  logic [XW-1:0] knob_x;
  logic [8:0]    q0;
  logic [RW-1:0] r0;
  logic [RW-1:0] r1;
  logic          ge1;
  logic          ge2;

  // 360 = 256 + 64 + 32 + 8
  assign knob_x = {9'd0, knob};
  assign prod   = (knob_x << 8) + (knob_x << 6) + (knob_x << 5) + (knob_x << 3);

  // 2^B - 1 divisor: quotient estimate by shift, remainder folded back in
  assign q0  = prod[XW-1:ADC_BITS];
  assign r0  = {2'b00, prod[ADC_BITS-1:0]} + RW'(q0);
  assign ge1 = (r0 >= FULL);
  assign r1  = ge1 ? (r0 - FULL) : r0;
  assign ge2 = (r1 >= FULL);

  assign quot = {1'b0, q0} + {9'd0, ge1} + {9'd0, ge2};

endmodule

`default_nettype wire

/* hw/rtl/lts_in_stage.sv */
// Input register stage: holds one accepted beat until the core consumes it.
`default_nettype none

module lts_in_stage #(
  parameter int IN_W = 56
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_tvalid,
  output logic                 in_tready,
  input  wire logic [IN_W-1:0] in_tdata,
  input  wire logic [1:0]      in_tuser,
  input  wire logic            take,
  output logic                 item_valid,
  output logic [IN_W-1:0]      item_data,
  output logic [1:0]           item_op
);

  logic            valid_r;
  logic [IN_W-1:0] data_r;
  logic [1:0]      op_r;
  logic            fire;

  assign fire      = valid_r & take;
  assign in_tready = ~valid_r | take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      valid_r <= 1'b1;
    end else if (fire) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
      op_r   <= in_tuser;
    end
  end

  assign item_valid = fire;
  assign item_data  = data_r;
  assign item_op    = op_r;

endmodule

`default_nettype wire

/* hw/rtl/lts_out_stage.sv */
// Result register stage: holds a finished result until the receiver takes it.
`default_nettype none

module lts_out_stage (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                res_valid,
  input  wire lts_pkg::result_t                    res,
  output logic                                     take,
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  output logic [lts_pkg::OUT_W-1:0]                out_tdata
);

  logic             valid_r;
  lts_pkg::result_t res_r;

  assign take = ~valid_r | out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (res_valid) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {(lts_pkg::OUT_W - lts_pkg::RES_W)'(0), res_r};

endmodule

`default_nettype wire

/* hw/rtl/lts_core.sv */
// Tracker state, configuration registers and the per-item update logic.
`default_nettype none

module lts_core #(
  parameter int ADC_BITS = 12,
  parameter int IN_W     = 56
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_we,
  input  wire logic [1:0]                cfg_addr,
  input  wire logic [lts_pkg::CFG_W-1:0] cfg_wdata,
  input  wire logic                      item_valid,
  input  wire logic [IN_W-1:0]           item_data,
  input  wire logic [1:0]                item_op,
  output lts_pkg::result_t               res
);

  localparam int B  = ADC_BITS;
  localparam int DW = ((B > lts_pkg::CFG_W) ? B : lts_pkg::CFG_W) + 2;

  // Configuration
  logic [lts_pkg::CFG_W-1:0]  light_hyst_r;
  logic [lts_pkg::CFG_W-1:0]  knob_hyst_r;
  logic [lts_pkg::SENS_W-1:0] sense_int_r;
  logic [lts_pkg::TOG_W-1:0]  debounce_r;

  // Tracker state
  logic                       auto_on_r,    auto_on_nxt;
  logic [8:0]                 pos_r,        pos_nxt;
  logic [7:0]                 remote_r,     remote_nxt;
  logic [B-1:0]               knob_ref_r,   knob_ref_nxt;
  logic                       knob_ld_r,    knob_ld_nxt;
  logic                       latched_r,    latched_nxt;
  logic                       last_btn_r,   last_btn_nxt;
  logic [lts_pkg::SENS_W-1:0] sense_el_r,   sense_el_nxt;
  logic [lts_pkg::TOG_W-1:0]  toggle_el_r,  toggle_el_nxt;
  logic [7:0]                 written_r,    written_nxt;
  lts_pkg::side_e             side_r,       side_nxt;
  logic                       led_r,        led_nxt;
  lts_pkg::reply_e            reply;

  // Item fields
  logic [B-1:0]       light_left;
  logic [B-1:0]       light_right;
  logic [B-1:0]       knob;
  logic               button_level;
  logic signed [9:0]  web_angle;
  logic [1:0]         web_mode;

  assign light_left   = item_data[B-1:0];
  assign light_right  = item_data[2*B-1:B];
  assign knob         = item_data[3*B-1:2*B];
  assign button_level = item_data[3*B];
  assign web_angle    = $signed(item_data[3*B+10:3*B+1]);
  assign web_mode     = item_data[3*B+12:3*B+11];

  // Derived tick terms
  logic [B-1:0]               ref_eff;
  logic [lts_pkg::SENS_W-1:0] sense_inc;
  logic [lts_pkg::TOG_W-1:0]  toggle_inc;
  logic signed [DW-1:0]       delta;
  logic signed [DW-1:0]       lhyst_s;
  logic signed [DW-1:0]       khyst_s;
  logic signed [DW-1:0]       knob_s;
  logic signed [DW-1:0]       ref_s;
  logic                       knob_moved;
  logic [9:0]                 map_q;
  logic [8:0]                 map_pos;
  logic [7:0]                 web_clamped;

  lts_knob_map #(.ADC_BITS(ADC_BITS)) u_map (
    .knob (knob),
    .quot (map_q)
  );

  assign ref_eff    = knob_ld_r ? knob_ref_r : knob;
  assign sense_inc  = (sense_el_r < lts_pkg::SENSE_SAT) ? sense_el_r + 1'b1 : sense_el_r;
  assign toggle_inc = (toggle_el_r < lts_pkg::TOGGLE_SAT) ? toggle_el_r + 1'b1 : toggle_el_r;

  assign delta   = $signed({{(DW-B){1'b0}}, light_left}) - $signed({{(DW-B){1'b0}}, light_right});
  assign lhyst_s = $signed({{(DW-lts_pkg::CFG_W){1'b0}}, light_hyst_r});
  assign khyst_s = $signed({{(DW-lts_pkg::CFG_W){1'b0}}, knob_hyst_r});
  assign knob_s  = $signed({{(DW-B){1'b0}}, knob});
  assign ref_s   = $signed({{(DW-B){1'b0}}, ref_eff});

  assign knob_moved = (knob_s > ref_s + khyst_s) || (knob_s < ref_s - khyst_s);

  // Clamp the mapped knob position to the legal half-degree range
  assign map_pos = (map_q > 10'(lts_pkg::POS_MAX)) ? lts_pkg::POS_MAX :
                   (map_q < 10'(lts_pkg::POS_MIN)) ? lts_pkg::POS_MIN : map_q[8:0];

  assign web_clamped = (web_angle < $signed(10'd1))   ? lts_pkg::ANGLE_MIN :
                       (web_angle > $signed(10'd179)) ? lts_pkg::ANGLE_MAX :
                       web_angle[7:0];

  always_comb begin
    auto_on_nxt   = auto_on_r;
    pos_nxt       = pos_r;
    remote_nxt    = remote_r;
    knob_ref_nxt  = knob_ref_r;
    knob_ld_nxt   = knob_ld_r;
    latched_nxt   = latched_r;
    last_btn_nxt  = last_btn_r;
    sense_el_nxt  = sense_el_r;
    toggle_el_nxt = toggle_el_r;
    written_nxt   = written_r;
    side_nxt      = side_r;
    led_nxt       = led_r;
    reply         = lts_pkg::RPL_NONE;

    case (lts_pkg::op_e'(item_op))
      lts_pkg::OP_TICK: begin
        knob_ref_nxt  = ref_eff;
        knob_ld_nxt   = 1'b1;
        sense_el_nxt  = sense_inc;
        toggle_el_nxt = toggle_inc;
        if (auto_on_r) begin
          if (sense_inc >= sense_int_r) begin
            sense_el_nxt = '0;
            if (delta > lhyst_s) begin
              side_nxt = lts_pkg::SIDE_LEFT;
              pos_nxt  = (pos_r > lts_pkg::POS_MIN) ? pos_r - 1'b1 : lts_pkg::POS_MIN;
            end else if (delta < -lhyst_s) begin
              side_nxt = lts_pkg::SIDE_RIGHT;
              pos_nxt  = (pos_r < lts_pkg::POS_MAX) ? pos_r + 1'b1 : lts_pkg::POS_MAX;
            end else begin
              side_nxt = lts_pkg::SIDE_CENTER;
            end
            written_nxt = pos_nxt[8:1];
          end
          led_nxt = 1'b0;
        end else begin
          latched_nxt  = latched_r | knob_moved;
          knob_ref_nxt = knob;
          if (latched_nxt) begin
            pos_nxt     = map_pos;
            written_nxt = map_pos[8:1];
          end else begin
            written_nxt = remote_r;
          end
          led_nxt = 1'b1;
        end
        // Button checked last so a toggle acts on the following tick
        if (button_level && !last_btn_r && (toggle_inc >= debounce_r)) begin
          auto_on_nxt   = ~auto_on_r;
          toggle_el_nxt = '0;
        end
        last_btn_nxt = button_level;
      end
      lts_pkg::OP_WEB_POS: begin
        auto_on_nxt = 1'b0;
        latched_nxt = 1'b0;
        remote_nxt  = web_clamped;
        written_nxt = web_clamped;
        reply       = lts_pkg::RPL_POS;
      end
      lts_pkg::OP_WEB_MODE: begin
        if (web_mode == lts_pkg::MODE_AUTO) begin
          auto_on_nxt = 1'b1;
          reply       = lts_pkg::RPL_AUTO;
        end else if (web_mode == lts_pkg::MODE_MANUAL) begin
          auto_on_nxt = 1'b0;
          reply       = lts_pkg::RPL_MANUAL;
        end else begin
          reply       = lts_pkg::RPL_REJECT;
        end
      end
      default: begin
        reply = lts_pkg::RPL_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      light_hyst_r <= lts_pkg::LIGHT_HYST_RST;
      knob_hyst_r  <= lts_pkg::KNOB_HYST_RST;
      sense_int_r  <= lts_pkg::SENSE_INT_RST;
      debounce_r   <= lts_pkg::DEBOUNCE_RST;
    end else if (cfg_we) begin
      case (lts_pkg::reg_e'(cfg_addr))
        lts_pkg::REG_LIGHT_HYST: light_hyst_r <= cfg_wdata;
        lts_pkg::REG_KNOB_HYST:  knob_hyst_r  <= cfg_wdata;
        lts_pkg::REG_SENSE_INT:  sense_int_r  <= cfg_wdata[lts_pkg::SENS_W-1:0];
        lts_pkg::REG_DEBOUNCE:   debounce_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_on_r   <= 1'b1;
      pos_r       <= lts_pkg::POS_RESET;
      remote_r    <= lts_pkg::ANGLE_RESET;
      knob_ld_r   <= 1'b0;
      latched_r   <= 1'b0;
      last_btn_r  <= 1'b0;
      sense_el_r  <= '0;
      toggle_el_r <= '0;
      written_r   <= lts_pkg::ANGLE_RESET;
      side_r      <= lts_pkg::SIDE_CENTER;
      led_r       <= 1'b0;
    end else if (item_valid) begin
      auto_on_r   <= auto_on_nxt;
      pos_r       <= pos_nxt;
      remote_r    <= remote_nxt;
      knob_ld_r   <= knob_ld_nxt;
      latched_r   <= latched_nxt;
      last_btn_r  <= last_btn_nxt;
      sense_el_r  <= sense_el_nxt;
      toggle_el_r <= toggle_el_nxt;
      written_r   <= written_nxt;
      side_r      <= side_nxt;
      led_r       <= led_nxt;
    end
  end

  // Reference only matters once loaded
  always_ff @(posedge clk) begin
    if (item_valid) begin
      knob_ref_r <= knob_ref_nxt;
    end
  end

  assign res.angle  = written_nxt;
  assign res.side   = side_nxt;
  assign res.manual = led_nxt;
  assign res.reply  = reply;

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r >= lts_pkg::POS_MIN) && (pos_r <= lts_pkg::POS_MAX))
    else $error("half-degree position left its range");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    (written_r >= lts_pkg::ANGLE_MIN) && (written_r <= lts_pkg::ANGLE_MAX))
    else $error("servo angle left its range");

  a_web_pos_manual: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && (item_op == lts_pkg::OP_WEB_POS) |=> !auto_on_r && !latched_r)
    else $error("web position did not force manual remote control");

  a_led_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && (item_op != lts_pkg::OP_TICK) |=> $stable(led_r) && $stable(sense_el_r))
    else $error("mode LED or sense counter moved on a web command");

  a_auto_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    item_valid && (item_op == lts_pkg::OP_TICK) && auto_on_r |=> !led_r)
    else $error("LED shows manual after an auto tick");
`endif

endmodule

`default_nettype wire

/* hw/rtl/light_tracker_servo_controller_unit.sv */
// Top level of the light tracker servo controller.
//
// Input channel (in_*): one beat per item. in_tuser carries the item kind:
// tick of one millisecond, web set position, or web set mode. Ticks carry the
// two light samples, the knob sample and the button level; web beats carry
// the requested angle or mode.
// Result channel (out_*): exactly one beat per input beat, in order, with the
// servo angle in whole degrees, the last tracking decision, the mode LED and
// the web reply code.
// Configuration port (cfg_*): write-only, one register per cycle while
// cfg_we is high; write only while no item is in flight.
// Timing: an accepted beat lands in the input register; when the result
// register can take it, the core updates its state and loads the result
// register, which raises out_tvalid. Throughput is one item per cycle while
// out_tready stays high, set by the combinational path between the registers.
// Stall: when out_tready is low the result register holds its beat and the
// input register can still take one more beat; in_tready drops only when
// both are full.
// Reset (rst_n low, synchronous): both registers empty, auto tracking on, 90
// degrees, default configuration; the knob reference loads on the first tick.
`default_nettype none

module light_tracker_servo_controller_unit #(
  parameter int ADC_BITS = 12,
  localparam int IN_W = ((3 * ADC_BITS + 13 + 7) / 8) * 8
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Input channel
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  // tdata low to high: light_left, light_right, knob (ADC_BITS each),
  // button_level, web_angle (10, signed), web_mode (2), zero fill
  input  wire logic [IN_W-1:0]              in_tdata,
  // tuser: op (2)
  input  wire logic [1:0]                   in_tuser,
  // Result channel
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  // tdata low to high: servo_angle (8), light_side (2), manual_mode (1),
  // reply (3), zero fill
  output logic [lts_pkg::OUT_W-1:0]         out_tdata,
  // Configuration
  input  wire logic                         cfg_we,
  input  wire logic [1:0]                   cfg_addr,
  input  wire logic [lts_pkg::CFG_W-1:0]    cfg_wdata
);

  logic             take;
  logic             item_valid;
  logic [IN_W-1:0]  item_data;
  logic [1:0]       item_op;
  lts_pkg::result_t res;

  // Hold one accepted beat ahead of the core
  lts_in_stage #(.IN_W(IN_W)) u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item_data  (item_data),
    .item_op    (item_op)
  );

  // Advance tracker state and form the result in one pass
  lts_core #(.ADC_BITS(ADC_BITS), .IN_W(IN_W)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .item_valid (item_valid),
    .item_data  (item_data),
    .item_op    (item_op),
    .res        (res)
  );

  // Hold the result until the receiver takes it
  lts_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .res_valid  (item_valid),
    .res        (res),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Self-checking stream testbench for the light tracker servo controller unit.
`timescale 1ns / 1ps

module tb_top;

  localparam int ADC_BITS    = 12;
  localparam int IN_W        = ((3 * ADC_BITS + 13 + 7) / 8) * 8;
  localparam int QUIET_LIMIT = 1000;

  // Codes the package leaves unnamed
  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam logic [1:0] MODE_BAD    = 2'd2;
  localparam logic [1:0] MODE_BAD_HI = 2'd3;

  // One input item, field by field
  typedef struct {
    logic [1:0]          op;
    logic [ADC_BITS-1:0] light_left;
    logic [ADC_BITS-1:0] light_right;
    logic [ADC_BITS-1:0] knob;
    logic                button;
    logic signed [9:0]   web_angle;
    logic [1:0]          web_mode;
  } tracker_cmd_t;

  logic                      clk;
  logic                      rst_n     = 1'b0;
  logic                      in_tvalid = 1'b0;
  logic                      in_tready;
  logic [IN_W-1:0]           in_tdata  = '0;
  logic [1:0]                in_tuser  = '0;
  logic                      out_tvalid;
  logic                      out_tready = 1'b0;
  logic [lts_pkg::OUT_W-1:0] out_tdata;
  logic                      cfg_we    = 1'b0;
  logic [1:0]                cfg_addr  = '0;
  logic [lts_pkg::CFG_W-1:0] cfg_wdata = '0;

  light_tracker_servo_controller_unit #(.ADC_BITS(ADC_BITS)) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Tracker predictor: its own copy of the registers and of the block's state,
  // starting from the reset values.
  // ---------------------------------------------------------------------------
  logic [lts_pkg::CFG_W-1:0]  light_band   = lts_pkg::LIGHT_HYST_RST;
  logic [lts_pkg::CFG_W-1:0]  knob_band    = lts_pkg::KNOB_HYST_RST;
  logic [lts_pkg::SENS_W-1:0] step_period  = lts_pkg::SENSE_INT_RST;
  logic [lts_pkg::TOG_W-1:0]  toggle_guard = lts_pkg::DEBOUNCE_RST;

  logic                       tracking_auto = 1'b1;
  logic [8:0]                 half_pos      = lts_pkg::POS_RESET;
  logic [7:0]                 remote_deg    = lts_pkg::ANGLE_RESET;
  logic [ADC_BITS-1:0]        knob_last     = '0;
  logic                       knob_last_ok  = 1'b0;
  logic                       knob_owns     = 1'b0;
  logic                       button_prev   = 1'b0;
  logic [lts_pkg::SENS_W-1:0] since_step    = '0;
  logic [lts_pkg::TOG_W-1:0]  since_toggle  = '0;
  logic [7:0]                 servo_deg     = lts_pkg::ANGLE_RESET;
  lts_pkg::side_e             side_last     = lts_pkg::SIDE_CENTER;
  logic                       led_manual    = 1'b0;

  // Run statistics for the closing summary
  int ticks_seen, web_seen, unused_seen, auto_steps, mode_toggles, knob_grabs;
  int settings_used, beats_checked, mismatches;

  function automatic logic [8:0] clamp_half(input int p);
    int lo, hi;
    lo = int'(lts_pkg::POS_MIN);
    hi = int'(lts_pkg::POS_MAX);
    if (p < lo) return lts_pkg::POS_MIN;
    if (p > hi) return lts_pkg::POS_MAX;
    return p[8:0];
  endfunction

  // Apply one command to the predicted state and return the result beat due
  function automatic lts_pkg::result_t advance_tracker(input tracker_cmd_t c);
    lts_pkg::result_t r;
    lts_pkg::reply_e  rep;
    int               delta, band, pos, k, ref_k, kb, mapped, ang, lo, hi;
    rep = lts_pkg::RPL_NONE;
    case (c.op)
      lts_pkg::OP_TICK: begin
        ticks_seen++;
        // Load the knob reference on the first tick, before it is used
        if (!knob_last_ok) begin
          knob_last    = c.knob;
          knob_last_ok = 1'b1;
        end
        if (since_step < lts_pkg::SENSE_SAT) since_step = since_step + 1'b1;
        if (since_toggle < lts_pkg::TOGGLE_SAT) since_toggle = since_toggle + 1'b1;
        if (tracking_auto) begin
          if (since_step >= step_period) begin
            delta      = int'(c.light_left) - int'(c.light_right);
            band       = int'(light_band);
            pos        = int'(half_pos);
            since_step = '0;
            auto_steps++;
            if (delta > band) begin
              side_last = lts_pkg::SIDE_LEFT;
              pos       = pos - 1;
            end else if (delta < -band) begin
              side_last = lts_pkg::SIDE_RIGHT;
              pos       = pos + 1;
            end else begin
              side_last = lts_pkg::SIDE_CENTER;
            end
            half_pos  = clamp_half(pos);
            servo_deg = half_pos[8:1];
          end
          led_manual = 1'b0;
        end else begin
          k     = int'(c.knob);
          ref_k = int'(knob_last);
          kb    = int'(knob_band);
          if ((k > ref_k + kb || k < ref_k - kb) && !knob_owns) begin
            knob_owns = 1'b1;
            knob_grabs++;
          end
          knob_last = c.knob;
          if (knob_owns) begin
            mapped = k * 360 / ((1 << ADC_BITS) - 1);
            hi     = int'(lts_pkg::POS_MAX);
            if (mapped > hi) mapped = hi;
            half_pos  = clamp_half(mapped);
            servo_deg = half_pos[8:1];
          end else begin
            servo_deg = remote_deg;
          end
          led_manual = 1'b1;
        end
        // The button is looked at last, so a toggle shows on the next tick
        if (c.button && !button_prev && since_toggle >= toggle_guard) begin
          tracking_auto = !tracking_auto;
          since_toggle  = '0;
          mode_toggles++;
        end
        button_prev = c.button;
      end
      lts_pkg::OP_WEB_POS: begin
        web_seen++;
        ang = int'(c.web_angle);
        lo  = int'(lts_pkg::ANGLE_MIN);
        hi  = int'(lts_pkg::ANGLE_MAX);
        if (ang < lo) ang = lo;
        if (ang > hi) ang = hi;
        tracking_auto = 1'b0;
        knob_owns     = 1'b0;
        remote_deg    = ang[7:0];
        servo_deg     = remote_deg;
        rep           = lts_pkg::RPL_POS;
      end
      lts_pkg::OP_WEB_MODE: begin
        web_seen++;
        if (c.web_mode == lts_pkg::MODE_AUTO) begin
          tracking_auto = 1'b1;
          rep           = lts_pkg::RPL_AUTO;
        end else if (c.web_mode == lts_pkg::MODE_MANUAL) begin
          tracking_auto = 1'b0;
          rep           = lts_pkg::RPL_MANUAL;
        end else begin
          rep = lts_pkg::RPL_REJECT;
        end
      end
      default: unused_seen++;
    endcase
    r.angle  = servo_deg;
    r.side   = side_last;
    r.manual = led_manual;
    r.reply  = rep;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Command builders and the random item generator
  // ---------------------------------------------------------------------------
  tracker_cmd_t     commands_to_send[$];
  lts_pkg::result_t servo_reports_due[$];
  int               cmds_queued;
  int               knob_walk;
  logic             btn_level;

  function automatic logic [ADC_BITS-1:0] clip_adc(input int v);
    if (v < 0) return '0;
    if (v > (1 << ADC_BITS) - 1) return '1;
    return v[ADC_BITS-1:0];
  endfunction

  function automatic tracker_cmd_t mk_tick(input int l, input int r, input int k, input bit b);
    tracker_cmd_t c;
    c             = '{default: '0};
    c.op          = lts_pkg::OP_TICK;
    c.light_left  = clip_adc(l);
    c.light_right = clip_adc(r);
    c.knob        = clip_adc(k);
    c.button      = b;
    return c;
  endfunction

  function automatic tracker_cmd_t mk_web(input logic [1:0] op, input int ang,
                                          input logic [1:0] m);
    tracker_cmd_t c;
    c           = '{default: '0};
    c.op        = op;
    c.web_angle = ang[9:0];
    c.web_mode  = m;
    return c;
  endfunction

  function automatic void queue_cmd(input tracker_cmd_t c);
    commands_to_send.push_back(c);
    cmds_queued++;
  endfunction

  // Tick with a chosen light lean: left brighter, right brighter, near balance,
  // or unrelated samples. The knob mostly wanders and now and then jumps.
  function automatic tracker_cmd_t rand_tick(input int lean);
    int base, swing, l, r, step;
    base  = int'($urandom_range(0, 4095));
    swing = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 4095))
                                        : int'($urandom_range(0, 300));
    case (lean)
      0: begin
        l = base + swing;
        r = base;
      end
      1: begin
        l = base;
        r = base + swing;
      end
      2: begin
        step = int'($urandom_range(0, 120));
        l    = base;
        r    = base + step - 60;
      end
      default: begin
        l = int'($urandom_range(0, 4095));
        r = int'($urandom_range(0, 4095));
      end
    endcase
    step = int'($urandom_range(0, 80));
    if ($urandom_range(0, 11) == 0) knob_walk = int'($urandom_range(0, 4095));
    else knob_walk = int'(clip_adc(knob_walk + step - 40));
    return mk_tick(l, r, knob_walk, btn_level);
  endfunction

  function automatic tracker_cmd_t rand_web();
    int ang;
    ang = ($urandom_range(0, 1) == 0) ? int'($urandom_range(1, 179))
                                      : int'($urandom_range(0, 1023));
    if ($urandom_range(0, 1) == 0) return mk_web(lts_pkg::OP_WEB_POS, ang, '0);
    return mk_web(lts_pkg::OP_WEB_MODE, 0, 2'($urandom_range(0, 3)));
  endfunction

  // Mostly tracking runs and button presses with random content; the rest is
  // web traffic and noise on every field, unused op included.
  task automatic fill_random(input int target);
    tracker_cmd_t c;
    int kind, lean;
    while (cmds_queued < target) begin
      kind = int'($urandom_range(0, 15));
      if (kind < 8) begin
        lean = int'($urandom_range(0, 3));
        repeat ($urandom_range(4, 80)) queue_cmd(rand_tick(lean));
      end else if (kind < 11) begin
        btn_level = 1'b1;
        repeat ($urandom_range(1, 3)) queue_cmd(rand_tick(3));
        btn_level = 1'b0;
        repeat ($urandom_range(1, 6)) queue_cmd(rand_tick(3));
      end else if (kind < 14) begin
        queue_cmd(rand_web());
      end else begin
        c             = mk_web(2'($urandom_range(0, 3)), int'($urandom_range(0, 1023)),
                               2'($urandom_range(0, 3)));
        c.light_left  = clip_adc(int'($urandom_range(0, 4095)));
        c.light_right = clip_adc(int'($urandom_range(0, 4095)));
        c.knob        = clip_adc(int'($urandom_range(0, 4095)));
        c.button      = 1'($urandom_range(0, 1));
        queue_cmd(c);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present one beat at a time from the pending queue, changing the
  // bus at the falling edge; hold a beat until the block takes it.
  // ---------------------------------------------------------------------------
  tracker_cmd_t on_bus;
  logic         in_took   = 1'b0;
  logic         out_took  = 1'b0;
  int           send_gap  = 0;
  bit           send_eager = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_took) begin
      // hold the offered beat
    end else if (send_gap > 0) begin
      in_tvalid <= 1'b0;
      send_gap  <= send_gap - 1;
    end else if (commands_to_send.size() > 0) begin
      on_bus    = commands_to_send.pop_front();
      in_tuser  <= on_bus.op;
      in_tdata  <= {{(IN_W - 3 * ADC_BITS - 13){1'b0}}, on_bus.web_mode, on_bus.web_angle,
                    on_bus.button, on_bus.knob, on_bus.light_right, on_bus.light_left};
      in_tvalid <= 1'b1;
      // flip now and then between back-to-back bursts and random gaps
      if ($urandom_range(0, 15) == 0) send_eager = !send_eager;
      send_gap  <= send_eager ? 0 : int'($urandom_range(0, 11));
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Long hold-off: once, in the middle of a phase, count a stretch of cycles
  // during which the receiver takes nothing, so the block fills and stalls.
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  bit stall_done = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (!stall_done && beats_checked >= 400 && commands_to_send.size() > 20) begin
      stall_left <= 96;
      stall_done <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls per beat and eager stretches; drop tready while
  // the long hold-off runs.
  // ---------------------------------------------------------------------------
  int recv_wait  = 0;
  bit recv_eager = 1'b0;
  int wait_draw;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
    end else if (recv_wait > 0) begin
      out_tready <= 1'b0;
      recv_wait  <= recv_wait - 1;
    end else if (out_took) begin
      if ($urandom_range(0, 15) == 0) recv_eager = !recv_eager;
      wait_draw = recv_eager ? 0 : int'($urandom_range(0, 11));
      out_tready <= (wait_draw == 0);
      recv_wait  <= (wait_draw == 0) ? 0 : wait_draw - 1;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard: at each rising edge compare a taken result beat with the
  // oldest one due, then predict for an input beat taken at the same edge.
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("MISMATCH at %0t, beat %0d: %s got %0d want %0d",
             $realtime, beats_checked, what, got, want);
  endtask

  lts_pkg::result_t got_beat, want_beat;

  always @(posedge clk) begin
    in_took  <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got_beat = lts_pkg::result_t'(out_tdata[lts_pkg::RES_W-1:0]);
      if (servo_reports_due.size() == 0) begin
        note_mismatch("result beat with none due, angle", int'(got_beat.angle), -1);
      end else begin
        want_beat = servo_reports_due.pop_front();
        if (got_beat.angle !== want_beat.angle)
          note_mismatch("servo_angle", int'(got_beat.angle), int'(want_beat.angle));
        if (got_beat.side !== want_beat.side)
          note_mismatch("light_side", int'(got_beat.side), int'(want_beat.side));
        if (got_beat.manual !== want_beat.manual)
          note_mismatch("manual_mode", int'(got_beat.manual), int'(want_beat.manual));
        if (got_beat.reply !== want_beat.reply)
          note_mismatch("reply", int'(got_beat.reply), int'(want_beat.reply));
      end
      beats_checked++;
    end
    if (rst_n && in_tvalid && in_tready) servo_reports_due.push_back(advance_tracker(on_bus));
  end

  // Watchdog: end the run if no beat moves on either side for too long
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("TIMEOUT: no beat moved for %0d cycles, %0d results still due",
               QUIET_LIMIT, servo_reports_due.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Register writes, only with nothing in flight
  // ---------------------------------------------------------------------------
  task automatic wait_drained();
    do @(posedge clk);
    while (commands_to_send.size() != 0 || in_tvalid || servo_reports_due.size() != 0);
    // let the two-stage pipe settle before touching the registers
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input lts_pkg::reg_e idx, input int val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val[lts_pkg::CFG_W-1:0];
    case (idx)
      lts_pkg::REG_LIGHT_HYST: light_band   = val[lts_pkg::CFG_W-1:0];
      lts_pkg::REG_KNOB_HYST:  knob_band    = val[lts_pkg::CFG_W-1:0];
      lts_pkg::REG_SENSE_INT:  step_period  = val[lts_pkg::SENS_W-1:0];
      lts_pkg::REG_DEBOUNCE:   toggle_guard = val[lts_pkg::TOG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int lh, input int kh, input int si, input int db);
    wait_drained();
    write_reg(lts_pkg::REG_LIGHT_HYST, lh);
    write_reg(lts_pkg::REG_KNOB_HYST, kh);
    write_reg(lts_pkg::REG_SENSE_INT, si);
    write_reg(lts_pkg::REG_DEBOUNCE, db);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings_used++;
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    knob_walk = 2048;
    btn_level = 1'b0;
    settings_used = 1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: first tick loads the knob reference at full scale,
    // web angles below and above range, a rejected mode, the unused op.
    queue_cmd(mk_tick(4095, 0, 4095, 1'b0));
    queue_cmd(mk_web(lts_pkg::OP_WEB_POS, -512, '0));
    queue_cmd(mk_web(lts_pkg::OP_WEB_POS, 511, '0));
    queue_cmd(mk_web(lts_pkg::OP_WEB_POS, 0, '0));
    queue_cmd(mk_web(lts_pkg::OP_WEB_MODE, 0, MODE_BAD));
    queue_cmd(mk_web(OP_UNUSED, 0, '0));

    // Zero bands, zero interval (a step on every tick), no debounce
    apply_settings(0, 0, 0, 0);
    queue_cmd(mk_web(lts_pkg::OP_WEB_MODE, 0, lts_pkg::MODE_AUTO));
    queue_cmd(mk_tick(4095, 0, 4095, 1'b0));      // step toward the left
    queue_cmd(mk_tick(0, 4095, 4095, 1'b0));      // step toward the right
    queue_cmd(mk_tick(100, 100, 4095, 1'b0));     // balanced, hold still
    queue_cmd(mk_tick(0, 0, 4095, 1'b1));         // press: manual from next tick
    queue_cmd(mk_tick(0, 0, 0, 1'b1));            // knob swing grabs, low end
    queue_cmd(mk_tick(0, 0, 4095, 1'b0));         // knob at full scale
    queue_cmd(mk_tick(0, 0, 4094, 1'b0));         // just under full, clamps high
    queue_cmd(mk_web(lts_pkg::OP_WEB_MODE, 0, MODE_BAD_HI));
    queue_cmd(mk_web(lts_pkg::OP_WEB_MODE, 0, lts_pkg::MODE_MANUAL));
    queue_cmd(mk_web(lts_pkg::OP_WEB_POS, 179, '0));  // drops the knob grab
    queue_cmd(mk_tick(0, 0, 4094, 1'b0));         // unmoved knob: web angle rules
    queue_cmd(mk_web(lts_pkg::OP_WEB_POS, 1, '0));
    queue_cmd(mk_tick(0, 0, 4094, 1'b1));         // press: back to auto next tick
    queue_cmd(mk_tick(0, 4095, 4094, 1'b1));      // held button, auto step
    queue_cmd(mk_web(lts_pkg::OP_WEB_MODE, 0, lts_pkg::MODE_AUTO));
    queue_cmd(mk_tick(2048, 2048, 2048, 1'b0));

    // Random phases: both extremes, a mixed one, then random settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: apply_settings(4095, 4095, 1023, 4095);
        1: apply_settings(0, 0, 0, 0);
        2: apply_settings(4095, 0, 1, 0);
        default: apply_settings(int'($urandom_range(0, 400)), int'($urandom_range(0, 120)),
                                int'($urandom_range(0, 12)), int'($urandom_range(0, 40)));
      endcase
      fill_random(cmds_queued + 90);
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (servo_reports_due.size() != 0)
      note_mismatch("results never delivered", 0, servo_reports_due.size());

    $display("Run covered %0d commands (%0d ticks, %0d web, %0d unused op) over %0d settings.",
             ticks_seen + web_seen + unused_seen, ticks_seen, web_seen, unused_seen,
             settings_used);
    $display("Predicted %0d auto steps, %0d mode toggles, %0d knob grabs; %0d beats compared.",
             auto_steps, mode_toggles, knob_grabs, beats_checked);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/lts_pkg.sv
hw/rtl/lts_knob_map.sv
hw/rtl/lts_in_stage.sv
hw/rtl/lts_out_stage.sv
hw/rtl/lts_core.sv
hw/rtl/light_tracker_servo_controller_unit.sv
test/tb_top.sv
